// ----- design/sactl_pkg.sv -----
// Shared types and constants for the set-associative cache tag lookup.
// Sizes, register indexes, the set row layout and the way-select result.
// No dependencies.
`default_nettype none

package sactl_pkg;

    // Cache geometry. SETS and WAYS must be powers of two.
    localparam int SETS   = 64;
    localparam int WAYS   = 4;
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int ADDR_W = 32;
    localparam int TAG_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 2'd2;

    localparam logic [2:0] OFFSET_BITS_RST = 3'd2;
    localparam logic [2:0] SET_BITS_RST    = 3'd6;
    localparam logic [2:0] SET_BITS_MAX    = 3'(SET_W);

    typedef enum logic {
        POLICY_LRU  = 1'b0,
        POLICY_FIFO = 1'b1
    } policy_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    // One memory row holds tag and stamp for every way of a set.
    typedef struct packed {
        logic [WAYS-1:0][STAMP_W-1:0] stamp;
        logic [WAYS-1:0][TAG_W-1:0]   tag;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Lookup outcome: hit flag and the way that hit or gets filled.
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } sel_t;

endpackage

`default_nettype wire

// ----- design/sactl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sactl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/sactl_way_sel.sv -----
// Way selection: tag match across the set, else first invalid way,
// else oldest stamp (ties to the lowest way). Uses sactl_pkg.
`default_nettype none

module sactl_way_sel (
    input  wire logic              [sactl_pkg::WAYS-1:0]  valid,
    input  wire sactl_pkg::row_t                          row,
    input  wire logic              [sactl_pkg::TAG_W-1:0] tag,
    output      sactl_pkg::sel_t                          sel
);
    import sactl_pkg::*;

    always_comb
    begin
        logic             found_hit;
        logic [WAY_W-1:0] hit_way;
        logic             found_free;
        logic [WAY_W-1:0] free_way;
        logic [WAY_W-1:0] old_way;
        logic [STAMP_W-1:0] old_stamp;

        found_hit  = 1'b0;
        hit_way    = '0;
        found_free = 1'b0;
        free_way   = '0;

        // Scan downward so the lowest matching way wins.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && (row.tag[w] == tag))
            begin
                found_hit = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!valid[w])
            begin
                found_free = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        // Oldest stamp; strict compare keeps ties on the lower way.
        old_way   = '0;
        old_stamp = row.stamp[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (row.stamp[w] < old_stamp)
            begin
                old_way   = WAY_W'(w);
                old_stamp = row.stamp[w];
            end
        end

        sel.hit = found_hit;
        priority if (found_hit)
        begin
            sel.way = hit_way;
        end
        else if (found_free)
        begin
            sel.way = free_way;
        end
        else
        begin
            sel.way = old_way;
        end
    end

endmodule

`default_nettype wire

// ----- design/set_assoc_cache_tag_lookup_core.sv -----
// Set-associative cache tag lookup core with LRU/FIFO replacement and hit/miss counters.
// Depends on sactl_pkg, sactl_ram (tag/stamp rows) and sactl_way_sel (match and victim).
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   cfg     | cfg_we, cfg_index, cfg_wdata               | in
//   in      | in_valid, in_stall, address                | in (stall out)
//   out     | out_valid, out_stall, hit, way_used,       | out (stall in)
//           | hit_count, miss_count                      |
//
// Each transaction first reads the set row from the tag/stamp RAM in idle
// (registered read), then compares, picks the way and writes the row back in lookup.
// A new address is taken only in idle; in_stall is high during the lookup cycle,
// so a read never meets a write to the same row.
// The result sits in an output register; the next address is accepted while it waits.
// The lookup cycle holds while that register is full and stalled.
// Reset clears all valid bits (flip-flops), counters and the access clock at once;
// RAM contents need no clearing since tag and stamp are only used for valid ways.
`default_nettype none

module set_assoc_cache_tag_lookup_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_we,
    input  wire logic [sactl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sactl_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic [sactl_pkg::ADDR_W-1:0]        address,

    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic                                hit,
    output      logic [sactl_pkg::WAY_W-1:0]         way_used,
    output      logic [sactl_pkg::CNT_W-1:0]         hit_count,
    output      logic [sactl_pkg::CNT_W-1:0]         miss_count
);
    import sactl_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] offset_bits_reg;
    logic [2:0] set_bits_reg;
    policy_t    policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            set_bits_reg    <= SET_BITS_RST;
            policy_reg      <= POLICY_LRU;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS:    offset_bits_reg <= cfg_wdata[2:0];
                CFG_SET_BITS:       set_bits_reg    <= cfg_wdata[2:0];
                CFG_REPLACE_POLICY: policy_reg      <= policy_t'(cfg_wdata[0]);
                default:            ; // unknown index is ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   in_accept;
    logic   lookup_done;
    logic   ram_re;
    logic   ram_we;
    logic   out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lookup_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        in_accept   = in_valid && (state_reg == ST_IDLE);
        // Finish only when the output register can take the result.
        lookup_done = (state_reg == ST_LOOKUP) && (!out_valid_reg || !out_stall);
        ram_re      = in_accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Address split: offset | set | tag
    // ------------------------------------------------------------------
    logic [2:0]        sb_eff;
    logic [5:0]        tag_shift;
    logic [ADDR_W-1:0] addr_shr;
    logic [ADDR_W-1:0] set_mask;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag_calc;

    always_comb
    begin
        // set width is clamped to what the array holds
        sb_eff    = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_reg;
        addr_shr  = address >> offset_bits_reg;
        set_mask  = (ADDR_W'(1) << sb_eff) - ADDR_W'(1);
        set_idx   = addr_shr[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift = {3'b000, offset_bits_reg} + {3'b000, sb_eff};
        tag_calc  = (tag_shift >= 6'd32) ? '0 : (address >> tag_shift);
    end

    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_calc;
        end
    end

    // ------------------------------------------------------------------
    // Tag/stamp RAM, one row per set
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] rd_bits;
    row_t             rd_row;
    row_t             wr_row;

    sactl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (wr_row),
        .re    (ram_re),
        .raddr (set_idx),
        .rdata (rd_bits)
    );

    assign rd_row = row_t'(rd_bits);

    // Valid bits live in flops so reset clears them all at once.
    logic [SETS-1:0][WAYS-1:0] valid_reg;
    sel_t                      sel;

    sactl_way_sel u_way_sel (
        .valid (valid_reg[set_reg]),
        .row   (rd_row),
        .tag   (tag_reg),
        .sel   (sel)
    );

    // ------------------------------------------------------------------
    // Read-modify-write of the row and counters
    // ------------------------------------------------------------------
    logic [STAMP_W-1:0] clock_reg;
    logic [STAMP_W-1:0] clock_next;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   hits_next;
    logic [CNT_W-1:0]   misses_reg;
    logic [CNT_W-1:0]   misses_next;

    always_comb
    begin
        wr_row      = rd_row;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        clock_next  = clock_reg + STAMP_W'(1);
        if (sel.hit)
        begin
            // LRU refreshes on hit; FIFO keeps the fill time
            if (policy_reg == POLICY_LRU)
            begin
                wr_row.stamp[sel.way] = clock_reg;
            end
            if (hits_reg != '1)
            begin
                hits_next = hits_reg + CNT_W'(1);
            end
        end
        else
        begin
            wr_row.tag[sel.way]   = tag_reg;
            wr_row.stamp[sel.way] = clock_reg;
            if (misses_reg != '1)
            begin
                misses_next = misses_reg + CNT_W'(1);
            end
        end
    end

    assign ram_we = lookup_done && (!sel.hit || (policy_reg == POLICY_LRU));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            clock_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else if (lookup_done)
        begin
            valid_reg[set_reg][sel.way] <= 1'b1;
            clock_reg  <= clock_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic               hit_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [CNT_W-1:0]   hit_count_reg;
    logic [CNT_W-1:0]   miss_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (lookup_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_done)
        begin
            hit_reg        <= sel.hit;
            way_reg        <= sel.way;
            hit_count_reg  <= hits_next;
            miss_count_reg <= misses_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign way_used   = way_reg;
    assign hit_count  = hit_count_reg;
    assign miss_count = miss_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("address taken without entering lookup");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("row write overlaps a row read");

    a_way_valid_after: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_done |=> valid_reg[set_reg][way_reg])
        else $error("way used is not valid after lookup");

    a_hit_keeps_misses: assert property (@(posedge clk) disable iff (!rst_n)
        (lookup_done && sel.hit) |=> (misses_reg == $past(misses_reg)))
        else $error("miss count moved on a hit");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without a lookup");

endmodule

`default_nettype wire

// ----- tb/tb_set_assoc_cache_tag_lookup_core.sv -----
// Testbench for set_assoc_cache_tag_lookup_core: random and directed lookups checked
// against a cycle-free model of the tag store, valid bits and LRU/FIFO victim choice.
// Depends on sactl_pkg and the core RTL; self-contained otherwise.

module tb_set_assoc_cache_tag_lookup_core;

    import sactl_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run
    localparam int HOLD_CYCLES     = 60;      // long receiver hold-off
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_PHASE      = 1;

    // Index 3 is not decoded; writes there must leave the settings alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // One expected lookup outcome.
    typedef struct {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } lookup_t;

    // Cache model plus queue of lookup outcomes still owed by the block.
    class lookup_scoreboard;
        bit                 line_valid [SETS*WAYS];
        logic [TAG_W-1:0]   line_tag   [SETS*WAYS];
        logic [STAMP_W-1:0] line_stamp [SETS*WAYS];
        logic [STAMP_W-1:0] access_clock;
        logic [CNT_W-1:0]   hits_total;
        logic [CNT_W-1:0]   misses_total;
        logic [2:0]         offset_bits;
        logic [2:0]         set_bits;
        policy_t            policy;
        lookup_t            lookups_due[$];
        int                 errors;

        function new();
            foreach (line_valid[i])
                line_valid[i] = 1'b0;
            access_clock = '0;
            hits_total   = '0;
            misses_total = '0;
            offset_bits  = OFFSET_BITS_RST;
            set_bits     = SET_BITS_RST;
            policy       = POLICY_LRU;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OFFSET_BITS:    offset_bits = val;
                CFG_SET_BITS:       set_bits = val;
                CFG_REPLACE_POLICY: policy = policy_t'(val[0]);
                default: ;
            endcase
        endfunction

        // Accepted address: update the model and queue the outcome it implies.
        function void note_access(logic [ADDR_W-1:0] addr);
            int unsigned      sb;
            int unsigned      shift;
            int unsigned      base;
            int unsigned      victim;
            logic [31:0]      set_idx;
            logic [TAG_W-1:0] tag;
            bit               found;
            bit               free;
            lookup_t          res;

            // set width is clipped to the number of physical sets
            sb      = (set_bits > SET_BITS_MAX) ? SET_W : set_bits;
            set_idx = (addr >> offset_bits) & ((32'd1 << sb) - 32'd1);
            shift   = offset_bits + sb;
            tag     = (shift >= 32) ? '0 : (addr >> shift);
            base    = set_idx * WAYS;
            found   = 1'b0;
            free    = 1'b0;
            victim  = 0;

            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && line_valid[base+w] && line_tag[base+w] == tag)
                begin
                    found  = 1'b1;
                    victim = w;
                end
            end

            if (found)
            begin
                if (policy == POLICY_LRU)
                    line_stamp[base+victim] = access_clock;
                if (hits_total != '1)
                    hits_total++;
            end
            else
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!free && !line_valid[base+w])
                    begin
                        free   = 1'b1;
                        victim = w;
                    end
                end
                // oldest stamp, lowest way on ties
                if (!free)
                begin
                    victim = 0;
                    for (int w = 1; w < WAYS; w++)
                        if (line_stamp[base+w] < line_stamp[base+victim])
                            victim = w;
                end
                line_valid[base+victim] = 1'b1;
                line_tag[base+victim]   = tag;
                line_stamp[base+victim] = access_clock;
                if (misses_total != '1)
                    misses_total++;
            end
            access_clock++;

            res.hit    = found;
            res.way    = WAY_W'(victim);
            res.hits   = hits_total;
            res.misses = misses_total;
            lookups_due.insert(lookups_due.size(), res);
        endfunction

        function void check_result(logic h, logic [WAY_W-1:0] w,
                                   logic [CNT_W-1:0] hc, logic [CNT_W-1:0] mc);
            lookup_t want;

            if (lookups_due.size() == 0)
            begin
                $error("result transaction with nothing pending: hit=%0d way=%0d", h, w);
                errors++;
                return;
            end
            want = lookups_due[0];
            lookups_due.delete(0);
            if (h !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, h);
                errors++;
            end
            if (w !== want.way)
            begin
                $error("way_used: expected %0d, got %0d", want.way, w);
                errors++;
            end
            if (hc !== want.hits)
            begin
                $error("hit_count: expected %0d, got %0d", want.hits, hc);
                errors++;
            end
            if (mc !== want.misses)
            begin
                $error("miss_count: expected %0d, got %0d", want.misses, mc);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [ADDR_W-1:0]     address;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic [WAY_W-1:0]      way_used;
    logic [CNT_W-1:0]      hit_count;
    logic [CNT_W-1:0]      miss_count;

    lookup_scoreboard sb;

    int unsigned cycles     = 0;
    int          hold_asks  = 0;   // bumped by the sender to request a long hold-off
    int          holds_done = 0;
    bit          quiet      = 1'b0; // last phase: no idling on either side

    // Address split currently programmed (set width already clipped).
    int unsigned cur_ob;
    int unsigned cur_sb;

    // Phase settings; extremes of every register appear somewhere.
    logic [2:0] ph_ob  [PHASES] = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd0};
    logic [2:0] ph_sb  [PHASES] = '{3'd6, 3'd0, 3'd7, 3'd4, 3'd2, 3'd6, 3'd7};
    policy_t    ph_pol [PHASES] = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                                    POLICY_LRU, POLICY_FIFO, POLICY_LRU};

    set_assoc_cache_tag_lookup_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .address    (address),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .way_used   (way_used),
        .hit_count  (hit_count),
        .miss_count (miss_count)
    );

    // 8-unit clock period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hang or a lost result ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor. Sampled at the edge, before any NBA of this step lands,
    // so out_stall is the value the block saw for this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(hit, way_used, hit_count, miss_count);
    end

    // Receiver: random stall bursts, quiet stretches, and on request one long
    // hold-off so the result register fills and the block backs up its input.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_asks != holds_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one address and hold it until the block takes the transaction.
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        in_valid <= 1'b1;
        address  <= addr;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_access(addr);
    endtask

    // Sender idle burst: in_valid drops and the address is randomised.
    task automatic sender_gap();
        in_valid <= 1'b0;
        address  <= $urandom;
        repeat ($urandom_range(1, 7)) @(posedge clk);
    endtask

    // Program every register (plus the undecoded index); block must be idle.
    task automatic apply_settings(input logic [2:0] ob, input logic [2:0] sbits,
                                  input policy_t pol);
        logic [CFG_DATA_W-1:0] junk;

        junk      = CFG_DATA_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OFFSET_BITS;
        cfg_wdata <= ob;
        @(posedge clk);
        sb.write_reg(CFG_OFFSET_BITS, ob);
        cfg_index <= CFG_SET_BITS;
        cfg_wdata <= sbits;
        @(posedge clk);
        sb.write_reg(CFG_SET_BITS, sbits);
        cfg_index <= CFG_UNUSED_IDX;
        cfg_wdata <= junk;
        @(posedge clk);
        sb.write_reg(CFG_UNUSED_IDX, junk);
        cfg_index <= CFG_REPLACE_POLICY;
        cfg_wdata <= CFG_DATA_W'(pol);
        @(posedge clk);
        sb.write_reg(CFG_REPLACE_POLICY, CFG_DATA_W'(pol));
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_ob = ob;
        cur_sb = (sbits > SET_BITS_MAX) ? SET_W : sbits;
    endtask

    // Wait for every owed result, then let the pipe settle.
    task automatic wait_idle();
        while (sb.lookups_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Address from tag, set and offset under the current split.
    function automatic logic [ADDR_W-1:0] build_addr(logic [31:0] tag, logic [31:0] set_idx,
                                                     logic [31:0] off);
        logic [31:0] set_mask;
        logic [31:0] off_mask;

        set_mask = (32'd1 << cur_sb) - 32'd1;
        off_mask = (32'd1 << cur_ob) - 32'd1;
        return (tag << (cur_ob + cur_sb)) | ((set_idx & set_mask) << cur_ob) | (off & off_mask);
    endfunction

    // Mostly a small pool of tags over a few sets, so hits, fills and
    // evictions all happen often; the rest is fully random noise.
    function automatic logic [ADDR_W-1:0] random_addr();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return build_addr($urandom_range(0, 5), $urandom_range(0, 3), $urandom);
    endfunction

    // Fill all four ways of one set, hit the first (refresh under LRU only),
    // then force two evictions and revisit the first tag.
    task automatic eviction_pattern(input int unsigned set_idx);
        for (int t = 1; t <= 4; t++)
            send_access(build_addr(t, set_idx, $urandom));
        send_access(build_addr(1, set_idx, $urandom));
        send_access(build_addr(5, set_idx, $urandom));
        send_access(build_addr(2, set_idx, $urandom));
        send_access(build_addr(1, set_idx, $urandom));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_OFFSET_BITS;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        address   = '0;
        sb        = new();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            apply_settings(ph_ob[ph], ph_sb[ph], ph_pol[ph]);
            if (ph == PHASES - 1)
                quiet = 1'b1;

            if (ph == 0)
            begin
                // address extremes: all zeros, all ones, alternating bits
                send_access(32'h0000_0000);
                send_access(32'h0000_0000);
                send_access(32'hFFFF_FFFF);
                send_access(32'hFFFF_FFFF);
                send_access(32'hAAAA_AAAA);
                send_access(32'h5555_5555);
            end
            eviction_pattern($urandom_range(0, 3));

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // sender keeps offering while the receiver holds off
                if (ph == HOLD_PHASE && i == 20)
                    hold_asks++;
                send_access(random_addr());
                if (!quiet && $urandom_range(0, 3) == 0)
                    sender_gap();
            end
            in_valid <= 1'b0;

            // sender pauses until every result is back; settings change only then
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.lookups_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
